[src/calendar_epoch_converter_top_assert.svh]
// Assertion macros for the calendar epoch converter
`ifndef CALENDAR_EPOCH_CONVERTER_TOP_ASSERT_SVH
`define CALENDAR_EPOCH_CONVERTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cec: same-cycle check failed");

// next-cycle implication
`define CEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cec: next-cycle check failed");

`else

`define CEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/cec_pkg.sv]
// Types, constants and helper functions for the calendar epoch converter
package cec_pkg;

    typedef enum logic [1:0] {
        OP_PACK2EP = 2'd0,
        OP_EP2PACK = 2'd1,
        OP_BCD2EP  = 2'd2,
        OP_EP2BCD  = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] packed_date;
        logic [31:0] epoch_in;
        logic [47:0] bcd_date;
    } req_t;

    typedef struct packed {
        logic [31:0] epoch_out;
        logic [31:0] packed_out;
        logic [47:0] bcd_out;
    } rsp_t;

    // day count of Jan 1 1970 offset for March-based year 1999
    localparam logic [15:0] YEAR_BASE_DAYS = 16'd10620;
    localparam logic [15:0] Y2K_DAYS       = 16'd10957;
    localparam logic [15:0] CLAMP_DAYS     = 16'd10967;
    localparam logic [15:0] QUAD_DAYS      = 16'd1461;
    localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
    localparam logic [10:0] YEAR_LEAP_LEN  = 11'd366;
    localparam logic [10:0] YEAR_LEN       = 11'd365;

    // reciprocals: q = (x * M) >> K, exact over the value range used
    localparam logic [25:0] RCP_675  = 26'd50903317;  // K = 35, x < 2^25
    localparam logic [17:0] RCP_60W  = 18'd139811;    // K = 23, x < 86400
    localparam logic [10:0] RCP_60N  = 11'd1093;      // K = 16, x < 1440
    localparam logic [15:0] RCP_1461 = 16'd45934;     // K = 26, x < 38754

    // floor(367 * m / 12), m = 1..13
    localparam logic [8:0] CUM_367 [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd0,   9'd0
    };

    // last day-of-year + 1 for each month, common year
    localparam logic [8:0] MONTH_END [12] = '{
        9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    function automatic logic [8:0] month_end(input logic [3:0] j, input logic leap);
        logic [8:0] e;
        e = MONTH_END[j] + ((j != 4'd0) ? {8'd0, leap} : 9'd0);
        return e;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] i, input logic leap);
        logic [8:0] s;
        s = (i == 4'd0) ? 9'd0 : month_end(i - 4'd1, leap);
        return s;
    endfunction

    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        logic [7:0] v;
        v = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'd0, b[3:0]};
        return v;
    endfunction

    function automatic logic [7:0] bcd_enc(input logic [5:0] v);
        logic [13:0] p;
        logic [2:0]  q;
        logic [5:0]  r;
        p = 14'(v) * 14'd205;
        q = p[13:11];
        r = v - 6'(q) * 6'd10;
        return {1'b0, q, r[3:0]};
    endfunction

    typedef struct packed {
        op_t         op;
        logic [6:0]  yy;
        logic [3:0]  mm;
        logic [4:0]  dy;
        logic [4:0]  hh;
        logic [5:0]  mi;
        logic [5:0]  ss;
        logic [15:0] days;
        logic [16:0] tlo;
    } s1_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] ydays;
        logic [16:0] tod;
        logic [16:0] sod;
        logic [15:0] dd;
    } s2_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ep;
        logic [16:0] sod;
        logic [10:0] mt;
        logic [15:0] dd;
        logic [4:0]  quad;
    } s3_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ep;
        logic [5:0]  ss;
        logic [10:0] mt;
        logic [4:0]  hh;
        logic [10:0] rem;
        logic [4:0]  quad;
    } s4_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ep;
        logic [5:0]  ss;
        logic [4:0]  hh;
        logic [5:0]  mi;
        logic [6:0]  year;
        logic [8:0]  yrem;
        logic        leap;
    } s5_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ep;
        logic [5:0]  ss;
        logic [4:0]  hh;
        logic [5:0]  mi;
        logic [6:0]  year;
        logic [8:0]  yrem;
        logic        leap;
        logic [3:0]  midx;
    } s6_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ep;
        logic [5:0]  year;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [4:0]  hh;
        logic [5:0]  mi;
        logic [5:0]  ss;
    } s7_t;

endpackage

[src/calendar_epoch_converter_top.sv]
// Calendar epoch converter: eight-stage pipeline between calendar words and epoch seconds
//
//  channel | handshake            | payload
//  --------+----------------------+------------------
//  req     | req_valid/req_ready  | cec_pkg::req_t
//  rsp     | rsp_valid/rsp_ready  | cec_pkg::rsp_t
//
// One item per cycle while rsp_ready stays high; rsp_valid shows an item in stage 8.
// Depth set by the divide-by-constant chain (86400, 60, 60, 1461) and month search.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stage holds when it is full and the next one cannot take its item;
// empty stages still fill, so bubbles close up under an output stall.

`include "calendar_epoch_converter_top_assert.svh"

module calendar_epoch_converter_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cec_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cec_pkg::rsp_t  rsp
);

    logic [8:1] v_reg;
    logic [8:1] v_next;
    logic [8:1] rdy;

    cec_pkg::s1_t  s1_reg, s1_next;
    cec_pkg::s2_t  s2_reg, s2_next;
    cec_pkg::s3_t  s3_reg, s3_next;
    cec_pkg::s4_t  s4_reg, s4_next;
    cec_pkg::s5_t  s5_reg, s5_next;
    cec_pkg::s6_t  s6_reg, s6_next;
    cec_pkg::s7_t  s7_reg, s7_next;
    cec_pkg::rsp_t rsp_reg, rsp_next;

    // ---------------- flow control ----------------
    assign rdy[8] = !v_reg[8] || rsp_ready;
    assign rdy[7] = !v_reg[7] || rdy[8];
    assign rdy[6] = !v_reg[6] || rdy[7];
    assign rdy[5] = !v_reg[5] || rdy[6];
    assign rdy[4] = !v_reg[4] || rdy[5];
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];

    assign req_ready = rdy[1];
    assign rsp_valid = v_reg[8];
    assign rsp       = rsp_reg;

    always_comb
    begin
        v_next[1] = rdy[1] ? req_valid : v_reg[1];
        v_next[2] = rdy[2] ? v_reg[1]  : v_reg[2];
        v_next[3] = rdy[3] ? v_reg[2]  : v_reg[3];
        v_next[4] = rdy[4] ? v_reg[3]  : v_reg[4];
        v_next[5] = rdy[5] ? v_reg[4]  : v_reg[5];
        v_next[6] = rdy[6] ? v_reg[5]  : v_reg[6];
        v_next[7] = rdy[7] ? v_reg[6]  : v_reg[7];
        v_next[8] = rdy[8] ? v_reg[7]  : v_reg[8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // ---------------- stage 1: field decode, days = t / 86400 ----------------
    always_comb
    begin
        logic [5:0]  yr;
        logic [3:0]  mo;
        logic        dec;
        logic [50:0] dprod;
        s1_next.op = req.op;
        if (req.op == cec_pkg::OP_BCD2EP)
        begin
            yr         = 6'(cec_pkg::bcd_dec(req.bcd_date[47:40]));
            mo         = 4'(cec_pkg::bcd_dec(req.bcd_date[39:32]));
            s1_next.dy = 5'(cec_pkg::bcd_dec(req.bcd_date[31:24]));
            s1_next.hh = 5'(cec_pkg::bcd_dec(req.bcd_date[23:16]));
            s1_next.mi = 6'(cec_pkg::bcd_dec(req.bcd_date[15:8]));
            s1_next.ss = 6'(cec_pkg::bcd_dec(req.bcd_date[7:0]));
        end
        else
        begin
            yr         = req.packed_date[31:26];
            mo         = req.packed_date[25:22];
            s1_next.dy = req.packed_date[21:17];
            s1_next.hh = req.packed_date[16:12];
            s1_next.mi = req.packed_date[11:6];
            s1_next.ss = req.packed_date[5:0];
        end
        // Jan and Feb count as months 11..12 of the previous year, month 0 as month 10
        dec        = (mo <= 4'd2);
        s1_next.yy = 7'(yr) + 7'd1 - 7'(dec);
        s1_next.mm = dec ? (mo + 4'd10) : (mo - 4'd2);
        dprod        = 51'(req.epoch_in[31:7]) * 51'(cec_pkg::RCP_675);
        s1_next.days = dprod[50:35];
        s1_next.tlo  = req.epoch_in[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && req_valid)
        begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- stage 2: day count, time of day, clamp ----------------
    always_comb
    begin
        logic [32:0] dsec;
        logic [15:0] dclamp;
        s2_next.op    = s1_reg.op;
        s2_next.ydays = cec_pkg::YEAR_BASE_DAYS
                      + 16'(s1_reg.yy) * 16'd365
                      + 16'((8'(s1_reg.yy) + 8'd3) >> 2)
                      + 16'(cec_pkg::CUM_367[s1_reg.mm])
                      + 16'(s1_reg.dy);
        s2_next.tod   = 17'(s1_reg.hh) * 17'd3600
                      + 17'(s1_reg.mi) * 17'd60
                      + 17'(s1_reg.ss);
        dsec          = 33'(s1_reg.days) * 33'(cec_pkg::SEC_PER_DAY);
        s2_next.sod   = s1_reg.tlo - dsec[16:0];
        dclamp        = (s1_reg.days < cec_pkg::Y2K_DAYS) ? cec_pkg::CLAMP_DAYS : s1_reg.days;
        s2_next.dd    = dclamp - cec_pkg::Y2K_DAYS;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2] && v_reg[1])
        begin
            s2_reg <= s2_next;
        end
    end

    // ---------------- stage 3: epoch out, minutes of day, 4-year cycles ----------------
    always_comb
    begin
        logic [34:0] mprod;
        logic [31:0] qprod;
        s3_next.op   = s2_reg.op;
        s3_next.ep   = 32'(s2_reg.ydays) * 32'(cec_pkg::SEC_PER_DAY) + 32'(s2_reg.tod);
        mprod        = 35'(s2_reg.sod) * 35'(cec_pkg::RCP_60W);
        s3_next.mt   = mprod[33:23];
        qprod        = 32'(s2_reg.dd) * 32'(cec_pkg::RCP_1461);
        s3_next.quad = qprod[30:26];
        s3_next.sod  = s2_reg.sod;
        s3_next.dd   = s2_reg.dd;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3] && v_reg[2])
        begin
            s3_reg <= s3_next;
        end
    end

    // ---------------- stage 4: seconds, hours, remainder in cycle ----------------
    always_comb
    begin
        logic [16:0] sdiff;
        logic [15:0] rdiff;
        logic [21:0] hprod;
        s4_next.op   = s3_reg.op;
        s4_next.ep   = s3_reg.ep;
        sdiff        = s3_reg.sod - 17'(s3_reg.mt) * 17'd60;
        s4_next.ss   = sdiff[5:0];
        rdiff        = s3_reg.dd - 16'(s3_reg.quad) * cec_pkg::QUAD_DAYS;
        s4_next.rem  = rdiff[10:0];
        hprod        = 22'(s3_reg.mt) * 22'(cec_pkg::RCP_60N);
        s4_next.hh   = hprod[20:16];
        s4_next.mt   = s3_reg.mt;
        s4_next.quad = s3_reg.quad;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4] && v_reg[3])
        begin
            s4_reg <= s4_next;
        end
    end

    // ---------------- stage 5: minutes, year within cycle ----------------
    always_comb
    begin
        logic [10:0] mdiff;
        logic [10:0] r2;
        logic [1:0]  yoff;
        logic [10:0] yr_rem;
        s5_next.op = s4_reg.op;
        s5_next.ep = s4_reg.ep;
        s5_next.ss = s4_reg.ss;
        s5_next.hh = s4_reg.hh;
        mdiff      = s4_reg.mt - 11'(s4_reg.hh) * 11'd60;
        s5_next.mi = mdiff[5:0];
        r2         = s4_reg.rem - cec_pkg::YEAR_LEAP_LEN;
        if (s4_reg.rem < cec_pkg::YEAR_LEAP_LEN)
        begin
            yoff         = 2'd0;
            yr_rem       = s4_reg.rem;
            s5_next.leap = 1'b1;
        end
        else if (r2 >= 11'd730)
        begin
            yoff         = 2'd3;
            yr_rem       = r2 - 11'd730;
            s5_next.leap = 1'b0;
        end
        else if (r2 >= cec_pkg::YEAR_LEN)
        begin
            yoff         = 2'd2;
            yr_rem       = r2 - cec_pkg::YEAR_LEN;
            s5_next.leap = 1'b0;
        end
        else
        begin
            yoff         = 2'd1;
            yr_rem       = r2;
            s5_next.leap = 1'b0;
        end
        s5_next.year = {s4_reg.quad, yoff};
        s5_next.yrem = yr_rem[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5] && v_reg[4])
        begin
            s5_reg <= s5_next;
        end
    end

    // ---------------- stage 6: month index ----------------
    always_comb
    begin
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int j = 0; j < 11; j++)
        begin
            cnt = cnt + 4'(s5_reg.yrem >= cec_pkg::month_end(4'(j), s5_reg.leap));
        end
        s6_next.op   = s5_reg.op;
        s6_next.ep   = s5_reg.ep;
        s6_next.ss   = s5_reg.ss;
        s6_next.hh   = s5_reg.hh;
        s6_next.mi   = s5_reg.mi;
        s6_next.year = s5_reg.year;
        s6_next.yrem = s5_reg.yrem;
        s6_next.leap = s5_reg.leap;
        s6_next.midx = cnt;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6] && v_reg[5])
        begin
            s6_reg <= s6_next;
        end
    end

    // ---------------- stage 7: day of month ----------------
    always_comb
    begin
        logic [8:0] dday;
        dday         = s6_reg.yrem - cec_pkg::month_start(s6_reg.midx, s6_reg.leap) + 9'd1;
        s7_next.op   = s6_reg.op;
        s7_next.ep   = s6_reg.ep;
        s7_next.year = s6_reg.year[5:0];
        s7_next.mon  = s6_reg.midx + 4'd1;
        s7_next.day  = dday[4:0];
        s7_next.hh   = s6_reg.hh;
        s7_next.mi   = s6_reg.mi;
        s7_next.ss   = s6_reg.ss;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7] && v_reg[6])
        begin
            s7_reg <= s7_next;
        end
    end

    // ---------------- stage 8: result formatting ----------------
    always_comb
    begin
        rsp_next = '0;
        case (s7_reg.op)
            cec_pkg::OP_PACK2EP, cec_pkg::OP_BCD2EP:
            begin
                rsp_next.epoch_out = s7_reg.ep;
            end
            cec_pkg::OP_EP2PACK:
            begin
                rsp_next.packed_out = {s7_reg.year, s7_reg.mon, s7_reg.day,
                                       s7_reg.hh, s7_reg.mi, s7_reg.ss};
            end
            cec_pkg::OP_EP2BCD:
            begin
                rsp_next.bcd_out = {cec_pkg::bcd_enc(s7_reg.year),
                                    cec_pkg::bcd_enc({2'b00, s7_reg.mon}),
                                    cec_pkg::bcd_enc({1'b0, s7_reg.day}),
                                    cec_pkg::bcd_enc({1'b0, s7_reg.hh}),
                                    cec_pkg::bcd_enc(s7_reg.mi),
                                    cec_pkg::bcd_enc(s7_reg.ss)};
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[8] && v_reg[7])
        begin
            rsp_reg <= rsp_next;
        end
    end

    // ---------------- checks ----------------
    logic [2:0] rsp_nz;
    assign rsp_nz = {rsp.epoch_out != '0, rsp.packed_out != '0, rsp.bcd_out != '0};

    `CEC_ASSERT_NOW(a_single_result_field, clk, rst_n, rsp_valid, $onehot0(rsp_nz))
    `CEC_ASSERT_NOW(a_month_index_range, clk, rst_n, v_reg[6], s6_reg.midx <= 4'd11)
    `CEC_ASSERT_NOW(a_cycle_rem_range, clk, rst_n, v_reg[4], s4_reg.rem < 11'(cec_pkg::QUAD_DAYS))
    `CEC_ASSERT_NEXT(a_stall_holds, clk, rst_n, v_reg[4] && !rdy[4], v_reg[4] && $stable(s4_reg))
    `CEC_ASSERT_NOW(a_empty_entry_ready, clk, rst_n, !v_reg[1], req_ready)

endmodule

[test/tb_calendar_epoch_converter_top.sv]
// Testbench for the calendar epoch converter: random and corner-case conversions checked against a local predictor
module tb_calendar_epoch_converter_top;

    typedef struct packed {
        logic [5:0] yr;
        logic [3:0] mo;
        logic [4:0] dy;
        logic [4:0] hh;
        logic [5:0] mi;
        logic [5:0] ss;
    } civil_t;

    localparam int unsigned EPOCH_DAY_BIAS = 719499;
    localparam int unsigned FIRST_Y2K_DAY  = 10957;
    localparam int unsigned CLAMPED_DAY    = 10967;
    localparam int unsigned DAYS_PER_QUAD  = 1461;
    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int          STALL_LIMIT    = 5000;
    localparam int          ITEMS_PER_PASS = 433;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    cec_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_ready;
    cec_pkg::rsp_t  rsp;

    logic           req_took = 1'b0;
    cec_pkg::req_t  req_backlog[$];
    cec_pkg::rsp_t  conversions_due[$];
    cec_pkg::rsp_t  want;
    int             errors = 0;
    int             idle_cycles = 0;
    int             send_idle_pct = 16;
    int             recv_stall_pct = 53;

    calendar_epoch_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    function automatic int unsigned month_days(int unsigned m, int unsigned leap);
        case (m)
            1:       return 28 + leap;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic logic [31:0] civil_to_epoch(civil_t c);
        int unsigned yr;
        int unsigned days;
        int          mon;
        yr  = c.yr + 2000;
        mon = int'(c.mo) - 2;
        if (mon <= 0)
        begin
            mon += 12;
            yr  -= 1;
        end
        days = yr / 4 - yr / 100 + yr / 400 + (367 * int'(mon)) / 12 + c.dy
               + yr * 365 - EPOCH_DAY_BIAS;
        return ((days * 24 + c.hh) * 60 + c.mi) * 60 + c.ss;
    endfunction

    function automatic civil_t split_epoch(logic [31:0] t);
        int unsigned days;
        int unsigned rem;
        int unsigned yr;
        int unsigned leap;
        int unsigned acc;
        int unsigned m;
        civil_t      c;
        c.ss = 6'(t % 60);
        c.mi = 6'((t % 3600) / 60);
        c.hh = 5'((t % SECS_PER_DAY) / 3600);
        days = t / SECS_PER_DAY;
        if (days < FIRST_Y2K_DAY)
            days = CLAMPED_DAY;
        yr  = ((days - FIRST_Y2K_DAY) / DAYS_PER_QUAD) * 4;
        rem = (days - FIRST_Y2K_DAY) % DAYS_PER_QUAD;
        if (rem >= 366)
        begin
            rem  -= 366;
            yr   += 1 + rem / 365;
            rem   = rem % 365;
            leap  = 0;
        end
        else
            leap = 1;
        acc = 0;
        m   = 0;
        while (m < 12 && acc + month_days(m, leap) <= rem)
        begin
            acc += month_days(m, leap);
            m++;
        end
        c.yr = 6'(yr);
        c.mo = 4'(m + 1);
        c.dy = 5'(rem - acc + 1);
        return c;
    endfunction

    function automatic int unsigned bcd_value(logic [7:0] b);
        return int'(b[7:4]) * 10 + b[3:0];
    endfunction

    function automatic logic [7:0] bcd_byte(int unsigned v);
        return {4'((v / 10) & 15), 4'(v % 10)};
    endfunction

    function automatic cec_pkg::rsp_t convert(cec_pkg::req_t r);
        cec_pkg::rsp_t o;
        civil_t        c;
        o = '0;
        case (r.op)
            cec_pkg::OP_PACK2EP: o.epoch_out = civil_to_epoch(r.packed_date);
            cec_pkg::OP_EP2PACK: o.packed_out = split_epoch(r.epoch_in);
            cec_pkg::OP_BCD2EP:
            begin
                c.yr = 6'(bcd_value(r.bcd_date[47:40]));
                c.mo = 4'(bcd_value(r.bcd_date[39:32]));
                c.dy = 5'(bcd_value(r.bcd_date[31:24]));
                c.hh = 5'(bcd_value(r.bcd_date[23:16]));
                c.mi = 6'(bcd_value(r.bcd_date[15:8]));
                c.ss = 6'(bcd_value(r.bcd_date[7:0]));
                o.epoch_out = civil_to_epoch(c);
            end
            default:
            begin
                c = split_epoch(r.epoch_in);
                o.bcd_out = {bcd_byte(c.yr), bcd_byte(c.mo), bcd_byte(c.dy),
                             bcd_byte(c.hh), bcd_byte(c.mi), bcd_byte(c.ss)};
            end
        endcase
        return o;
    endfunction

    function automatic civil_t civil(int unsigned y, int unsigned mo, int unsigned d,
                                     int unsigned h, int unsigned mi, int unsigned s);
        civil_t c;
        c.yr = 6'(y);
        c.mo = 4'(mo);
        c.dy = 5'(d);
        c.hh = 5'(h);
        c.mi = 6'(mi);
        c.ss = 6'(s);
        return c;
    endfunction

    // unused fields get random content
    task automatic add_req(cec_pkg::op_t op, logic [47:0] v);
        cec_pkg::req_t r;
        r.op          = op;
        r.packed_date = $urandom;
        r.epoch_in    = $urandom;
        r.bcd_date    = {16'($urandom), 32'($urandom)};
        case (op)
            cec_pkg::OP_PACK2EP:                      r.packed_date = v[31:0];
            cec_pkg::OP_EP2PACK, cec_pkg::OP_EP2BCD:  r.epoch_in = v[31:0];
            default:                                  r.bcd_date = v;
        endcase
        req_backlog.push_back(r);
    endtask

    task automatic add_random_req();
        cec_pkg::op_t op;
        logic [47:0]  v;
        op = cec_pkg::op_t'($urandom_range(3));
        v  = {16'($urandom), 32'($urandom)};
        case (op)
            cec_pkg::OP_PACK2EP:
                if ($urandom_range(99) < 75)
                    v = 48'(civil($urandom_range(63), $urandom_range(12, 1),
                                  $urandom_range(31, 1), $urandom_range(23),
                                  $urandom_range(59), $urandom_range(59)));
            cec_pkg::OP_BCD2EP:
                if ($urandom_range(99) < 75)
                    v = {bcd_byte($urandom_range(99)), bcd_byte($urandom_range(12, 1)),
                         bcd_byte($urandom_range(31, 1)), bcd_byte($urandom_range(23)),
                         bcd_byte($urandom_range(59)), bcd_byte($urandom_range(59))};
            default:
                if ($urandom_range(99) < 60)
                    v = 48'($urandom_range(32'hFFFF_FFFF, 32'd946684800));
        endcase
        add_req(op, v);
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] exp_val);
        $display("mismatch %s: got %h, want %h at %0t", what, got, exp_val, $time);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_took)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
        rsp_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        req_took <= rst_n && req_valid && req_ready;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                conversions_due.push_back(convert(req));
            if (rsp_valid && rsp_ready)
            begin
                if (conversions_due.size() == 0)
                    report_mismatch("unexpected item", 48'(rsp.epoch_out), 48'd0);
                else
                begin
                    want = conversions_due.pop_front();
                    if (rsp.epoch_out !== want.epoch_out)
                        report_mismatch("epoch_out", 48'(rsp.epoch_out), 48'(want.epoch_out));
                    if (rsp.packed_out !== want.packed_out)
                        report_mismatch("packed_out", 48'(rsp.packed_out),
                                        48'(want.packed_out));
                    if (rsp.bcd_out !== want.bcd_out)
                        report_mismatch("bcd_out", rsp.bcd_out, want.bcd_out);
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // packed to seconds: Y2K, top of range, all-zero and all-one words, month edges
        add_req(cec_pkg::OP_PACK2EP, 48'(civil(0, 1, 1, 0, 0, 0)));
        add_req(cec_pkg::OP_PACK2EP, 48'(civil(63, 12, 31, 23, 59, 59)));
        add_req(cec_pkg::OP_PACK2EP, 48'h0);
        add_req(cec_pkg::OP_PACK2EP, 48'hFFFF_FFFF);
        add_req(cec_pkg::OP_PACK2EP, 48'(civil(10, 2, 29, 12, 30, 30)));
        add_req(cec_pkg::OP_PACK2EP, 48'(civil(5, 3, 1, 0, 0, 0)));
        add_req(cec_pkg::OP_PACK2EP, 48'(civil(7, 13, 0, 31, 63, 63)));
        add_req(cec_pkg::OP_PACK2EP, 48'(civil(0, 15, 31, 24, 60, 60)));
        // seconds to packed: clamp region, Y2K, leap day, year end, 6-bit wrap, top of range
        add_req(cec_pkg::OP_EP2PACK, 48'd0);
        add_req(cec_pkg::OP_EP2PACK, 48'd946684799);
        add_req(cec_pkg::OP_EP2PACK, 48'd946684800);
        add_req(cec_pkg::OP_EP2PACK, 48'd951782400);
        add_req(cec_pkg::OP_EP2PACK, 48'd978307199);
        add_req(cec_pkg::OP_EP2PACK, 48'd2966371200);
        add_req(cec_pkg::OP_EP2PACK, 48'hFFFF_FFFF);
        // BCD to seconds: valid dates, nibbles above nine
        add_req(cec_pkg::OP_BCD2EP, 48'h000101000000);
        add_req(cec_pkg::OP_BCD2EP, 48'h991231235959);
        add_req(cec_pkg::OP_BCD2EP, 48'hFFFF_FFFF_FFFF);
        add_req(cec_pkg::OP_BCD2EP, 48'h240229123456);
        // seconds to BCD
        add_req(cec_pkg::OP_EP2BCD, 48'd0);
        add_req(cec_pkg::OP_EP2BCD, 48'hFFFF_FFFF);
        add_req(cec_pkg::OP_EP2BCD, 48'd2966371200);
        add_req(cec_pkg::OP_EP2BCD, 48'd4107560400);

        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 53;
                end
                1:
                begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 16;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PASS) add_random_req();
            while (req_backlog.size() != 0 || req_valid || conversions_due.size() != 0)
                @(posedge clk);
        end

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
